// File: hdl/spi_pkg.sv
// Shared types and constants for the spectral peak interpolator.
package spi_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SPACING_W = 16;
    localparam int FREQ_W = 24;
    localparam int POWER_W = 18;
    localparam int BIN_W = 7;
    localparam int ORD_W = 7;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_IDX_W = 2;

    localparam int DIV_W = 20;
    localparam int QUO_W = 24;
    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] FREQ_STEPS = 4'd12;
    localparam logic [STEP_W-1:0] POWER_STEPS = 4'd9;

    localparam logic signed [SAMPLE_W-1:0] RST_THRESHOLD = 16'sd410;
    localparam logic [SPACING_W-1:0] RST_SPACING = 16'd256;

    localparam logic [FREQ_W-1:0] FREQ_MAX = 24'hFFFFFF;
    localparam logic signed [POWER_W-1:0] POWER_MAX = 18'sh1FFFF;
    localparam logic signed [POWER_W-1:0] POWER_MIN = 18'sh20000;
    localparam logic [ORD_W-1:0] ORD_MAX = 7'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEAK_MODE   = 2'd0,
        CFG_THRESHOLD   = 2'd1,
        CFG_BIN_SPACING = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem_init;
        logic [QUO_W-1:0]  low_bits;
        logic [DIV_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: hdl/spi_div.sv
// Radix-4 restoring unsigned divider, two quotient bits per cycle.
module spi_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  spi_pkg::div_req_t          req,
    output spi_pkg::div_stat_t         stat,
    output logic [spi_pkg::QUO_W-1:0]  quotient
);
    import spi_pkg::*;

    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  low_reg, low_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIV_W-1:0]  rem_v;
    logic [QUO_W-1:0]  low_v;
    logic [QUO_W-1:0]  quo_v;
    logic [DIV_W:0]    trial;

    always_comb
    begin
        rem_v = rem_reg;
        low_v = low_reg;
        quo_v = quo_reg;
        trial = '0;
        for (int i = 0; i < 2; i++)
        begin
            trial = {rem_v, low_v[QUO_W-1]};
            low_v = {low_v[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial = trial - {1'b0, dvs_reg};
                quo_v = {quo_v[QUO_W-2:0], 1'b1};
            end
            else
            begin
                quo_v = {quo_v[QUO_W-2:0], 1'b0};
            end
            rem_v = trial[DIV_W-1:0];
        end
    end

    always_comb
    begin
        rem_next = rem_reg;
        low_next = low_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = req.rem_init;
            low_next = req.low_bits;
            quo_next = '0;
            dvs_next = req.divisor;
            cnt_next = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = rem_v;
            low_next = low_v;
            quo_next = quo_v;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/spectral_peak_interpolator.sv
// Spectral peak interpolator: three-point parabolic fit of local extrema.
// Items without a peak are taken one per cycle with no result.
// A peak item passes MUL_NUM, MUL_FREQ, DIV_FREQ, WAIT_FREQ, WAIT_PWR, OUT; ready then returns.
// They use one shared multiplier and a radix-4 divider (12 + 9 steps); OUT waits on the output.
// Reset (async, active low): config to defaults; history, counts, output cleared.
module spectral_peak_interpolator #(
    parameter int MAX_FRAME = 128
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [spi_pkg::SAMPLE_W-1:0]     s_axis_tdata,  // sample
    input  logic                             s_axis_tuser,  // frame_start
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [spi_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // frequency, power, bin_index, peak_ordinal
    input  logic                             cfg_we,
    input  logic [spi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spi_pkg::SAMPLE_W-1:0]     cfg_data
);
    import spi_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int PROD_W = MUL_A_W + MUL_B_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_NUM,
        S_MUL_FREQ,
        S_DIV_FREQ,
        S_WAIT_FREQ,
        S_WAIT_PWR,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic                         mode_reg, mode_next;
    logic signed [SAMPLE_W-1:0]   thresh_reg, thresh_next;
    logic [SPACING_W-1:0]         spacing_reg, spacing_next;
    logic signed [SAMPLE_W-1:0]   old_reg, old_next;
    logic signed [SAMPLE_W-1:0]   new_reg, new_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [ORD_W-1:0]             peaks_reg, peaks_next;
    logic                         out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]        out_data_reg, out_data_next;

    logic signed [SAMPLE_W-1:0]   z_reg, z_next;
    logic [16:0]                  an_reg, an_next;
    logic signed [16:0]           bn_reg, bn_next;
    logic [15:0]                  b2abs_reg, b2abs_next;
    logic                         a2neg_reg, a2neg_next;
    logic [CNT_W-1:0]             m_reg, m_next;
    logic [ORD_W-1:0]             ord_reg, ord_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic                         numpos_reg, numpos_next;
    logic                         fsat_reg, fsat_next;
    logic                         psat_reg, psat_next;
    logic [FREQ_W-1:0]            freq_reg, freq_next;
    logic signed [POWER_W-1:0]    pw_reg, pw_next;

    logic                         accept;
    logic                         fs;
    logic signed [SAMPLE_W-1:0]   s_val;
    logic [CNT_W-1:0]             cnt_eff;
    logic signed [SAMPLE_W-1:0]   old_eff;
    logic signed [SAMPLE_W-1:0]   new_eff;
    logic [ORD_W-1:0]             peaks_eff;
    logic                         hit;
    logic signed [17:0]           a2;
    logic signed [17:0]           a2_neg;
    logic signed [16:0]           b2;
    logic signed [16:0]           b2_neg;
    logic                         produce;
    logic [MUL_B_W-1:0]           m_ext;

    logic [MUL_A_W-1:0]           mul_a;
    logic [MUL_B_W-1:0]           mul_b;
    logic [PROD_W-1:0]            mul_p;
    logic signed [32:0]           num_s;

    logic signed [19:0]           z_ext;
    logic signed [19:0]           corr_ext;
    logic signed [19:0]           pw_sum;

    div_req_t                     div_req;
    div_stat_t                    div_stat;
    logic [QUO_W-1:0]             div_quo;

    spi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign fs = s_axis_tuser;
    assign s_val = s_axis_tdata;

    // frame mark clears history before the window test
    assign cnt_eff = fs ? '0 : cnt_reg;
    assign old_eff = fs ? '0 : old_reg;
    assign new_eff = fs ? '0 : new_reg;
    assign peaks_eff = fs ? '0 : peaks_reg;

    assign hit = mode_reg ? ((old_eff < new_eff) && (new_eff > s_val))
                          : ((old_eff > new_eff) && (new_eff < s_val));
    assign a2 = 18'(s_val) + 18'(old_eff) - (18'(new_eff) <<< 1);
    assign a2_neg = -a2;
    assign b2 = 17'(s_val) - 17'(old_eff);
    assign b2_neg = -b2;

    assign produce = accept && (cnt_eff < CNT_W'(MAX_FRAME)) && (cnt_eff >= CNT_W'(2))
                     && hit && (new_eff > thresh_reg) && (a2 != '0);

    assign m_ext = MUL_B_W'(m_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_NUM:
            begin
                mul_a = MUL_A_W'({an_reg, 1'b0});
                mul_b = m_ext;
            end
            S_MUL_FREQ:
            begin
                mul_a = num_s[MUL_A_W-1:0];
                mul_b = MUL_B_W'(spacing_reg);
            end
            S_DIV_FREQ:
            begin
                mul_a = MUL_A_W'(b2abs_reg);
                mul_b = MUL_B_W'(b2abs_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign num_s = $signed({1'b0, prod_reg[MUL_A_W-1:0]}) - 33'(bn_reg);

    assign z_ext = 20'(z_reg);
    assign corr_ext = $signed({2'b00, div_quo[POWER_W-1:0]});
    assign pw_sum = a2neg_reg ? (z_ext + corr_ext) : (z_ext - corr_ext);

    always_comb
    begin
        state_next = state_reg;
        mode_next = mode_reg;
        thresh_next = thresh_reg;
        spacing_next = spacing_reg;
        old_next = old_reg;
        new_next = new_reg;
        cnt_next = cnt_reg;
        peaks_next = peaks_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next = out_data_reg;

        z_next = z_reg;
        an_next = an_reg;
        bn_next = bn_reg;
        b2abs_next = b2abs_reg;
        a2neg_next = a2neg_reg;
        m_next = m_reg;
        ord_next = ord_reg;
        prod_next = prod_reg;
        numpos_next = numpos_reg;
        fsat_next = fsat_reg;
        psat_next = psat_reg;
        freq_next = freq_reg;
        pw_next = pw_reg;

        div_req = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PEAK_MODE:   mode_next = cfg_data[0];
                CFG_THRESHOLD:   thresh_next = cfg_data;
                CFG_BIN_SPACING: spacing_next = cfg_data;
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (fs || (cnt_reg < CNT_W'(MAX_FRAME))))
                begin
                    old_next = new_eff;
                    new_next = s_val;
                    cnt_next = cnt_eff + 1'b1;
                    peaks_next = peaks_eff;
                    if (produce)
                    begin
                        if (peaks_eff < ORD_MAX)
                        begin
                            peaks_next = peaks_eff + 1'b1;
                        end
                        z_next = new_eff;
                        an_next = a2[17] ? a2_neg[16:0] : a2[16:0];
                        bn_next = a2[17] ? b2_neg : b2;
                        b2abs_next = b2[16] ? b2_neg[15:0] : b2[15:0];
                        a2neg_next = a2[17];
                        m_next = cnt_eff - 1'b1;
                        ord_next = peaks_eff;
                        state_next = S_MUL_NUM;
                    end
                end
            end
            S_MUL_NUM:
            begin
                prod_next = mul_p;
                state_next = S_MUL_FREQ;
            end
            S_MUL_FREQ:
            begin
                numpos_next = !num_s[32] && (num_s != '0);
                prod_next = mul_p;
                state_next = S_DIV_FREQ;
            end
            S_DIV_FREQ:
            begin
                div_req.start = 1'b1;
                div_req.rem_init = prod_reg[43:24];
                div_req.low_bits = prod_reg[23:0];
                div_req.divisor = DIV_W'({an_reg, 1'b0});
                div_req.steps = FREQ_STEPS;
                fsat_next = prod_reg[47:24] >= 24'({an_reg, 1'b0});
                prod_next = mul_p;
                state_next = S_WAIT_FREQ;
            end
            S_WAIT_FREQ:
            begin
                if (div_stat.done)
                begin
                    if (!numpos_reg)
                    begin
                        freq_next = '0;
                    end
                    else if (fsat_reg)
                    begin
                        freq_next = FREQ_MAX;
                    end
                    else
                    begin
                        freq_next = div_quo;
                    end
                    div_req.start = 1'b1;
                    div_req.rem_init = DIV_W'(prod_reg[33:18]);
                    div_req.low_bits = {prod_reg[17:0], 6'b000000};
                    div_req.divisor = {an_reg, 3'b000};
                    div_req.steps = POWER_STEPS;
                    psat_next = DIV_W'(prod_reg[33:18]) >= {an_reg, 3'b000};
                    state_next = S_WAIT_PWR;
                end
            end
            S_WAIT_PWR:
            begin
                if (div_stat.done)
                begin
                    if (psat_reg)
                    begin
                        pw_next = a2neg_reg ? POWER_MAX : POWER_MIN;
                    end
                    else if (pw_sum > 20'(POWER_MAX))
                    begin
                        pw_next = POWER_MAX;
                    end
                    else if (pw_sum < 20'(POWER_MIN))
                    begin
                        pw_next = POWER_MIN;
                    end
                    else
                    begin
                        pw_next = pw_sum[POWER_W-1:0];
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = {ord_reg, m_ext[BIN_W-1:0], pw_reg, freq_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg <= 1'b1;
            thresh_reg <= RST_THRESHOLD;
            spacing_reg <= RST_SPACING;
            old_reg <= '0;
            new_reg <= '0;
            cnt_reg <= '0;
            peaks_reg <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg <= mode_next;
            thresh_reg <= thresh_next;
            spacing_reg <= spacing_next;
            old_reg <= old_next;
            new_reg <= new_next;
            cnt_reg <= cnt_next;
            peaks_reg <= peaks_next;
            out_valid_reg <= out_valid_next;
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg <= z_next;
        an_reg <= an_next;
        bn_reg <= bn_next;
        b2abs_reg <= b2abs_next;
        a2neg_reg <= a2neg_next;
        m_reg <= m_next;
        ord_reg <= ord_next;
        prod_reg <= prod_next;
        numpos_reg <= numpos_next;
        fsat_reg <= fsat_next;
        psat_reg <= psat_next;
        freq_reg <= freq_next;
        pw_reg <= pw_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_FRAME))
        else $error("bin count beyond frame limit");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while sequencer idle");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> (cnt_reg == CNT_W'(1)))
        else $error("frame mark did not restart bin count");
`endif

endmodule

// File: test/tb.sv
// Self-checking testbench for spectral_peak_interpolator: directed table, then random frames.
`timescale 1ns / 1ps

module tb;
    import spi_pkg::*;

    localparam int FRAME_BINS = 128;
    localparam int RANDOM_PER_PHASE = 67;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [FREQ_W-1:0]          freq;
        logic signed [POWER_W-1:0]  power;
        logic [BIN_W-1:0]           bin;
        logic [ORD_W-1:0]           ord;
    } peak_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NO_PEAK,
        ROW_PEAK
    } row_kind_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       fs;
        row_kind_t                  kind;
        peak_t                      want;
    } bin_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [SAMPLE_W-1:0]        s_axis_tdata = '0;
    logic                       s_axis_tuser = 1'b0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]      m_axis_tdata;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [SAMPLE_W-1:0]        cfg_data = '0;

    // predictor state and register shadow
    logic                       mode_sh = 1'b1;
    logic signed [SAMPLE_W-1:0] thr_sh = RST_THRESHOLD;
    logic [SPACING_W-1:0]       spacing_sh = RST_SPACING;
    logic signed [SAMPLE_W-1:0] hist_old = '0;
    logic signed [SAMPLE_W-1:0] hist_new = '0;
    int                         bin_count = 0;
    int                         peak_count = 0;

    peak_t                      expected_peaks [$];
    int                         mismatches = 0;
    int                         cycles = 0;
    int                         burst_left = 0;

    bin_row_t dir_rows [25] = '{
        '{16'sd0,      1'b0, ROW_NO_PEAK, '0},
        '{16'sd4096,   1'b0, ROW_NO_PEAK, '0},
        '{16'sd0,      1'b0, ROW_PEAK,    '{24'd256, 18'sd4096, 7'd1, 7'd0}},
        '{16'sd4096,   1'b0, ROW_PREDICT, '0},
        '{16'sd0,      1'b0, ROW_PEAK,    '{24'd768, 18'sd4096, 7'd3, 7'd1}},
        '{16'sh7FFF,   1'b0, ROW_PREDICT, '0},
        '{16'sh8000,   1'b0, ROW_PREDICT, '0},
        '{16'sh8000,   1'b0, ROW_PREDICT, '0},
        '{16'sh8000,   1'b0, ROW_PREDICT, '0},
        '{16'sh7FFF,   1'b0, ROW_PREDICT, '0},
        '{16'sh7FFF,   1'b0, ROW_PREDICT, '0},
        '{16'sd0,      1'b0, ROW_PREDICT, '0},
        '{16'sd410,    1'b0, ROW_PREDICT, '0},
        '{16'sd0,      1'b0, ROW_NO_PEAK, '0},
        '{16'sd411,    1'b0, ROW_PREDICT, '0},
        '{16'sd0,      1'b0, ROW_PREDICT, '0},
        '{16'sd20000,  1'b0, ROW_PREDICT, '0},
        '{16'sd0,      1'b1, ROW_NO_PEAK, '0},
        '{16'sd5000,   1'b0, ROW_NO_PEAK, '0},
        '{16'sd100,    1'b0, ROW_PREDICT, '0},
        '{-16'sd1,     1'b0, ROW_PREDICT, '0},
        '{-16'sd20000, 1'b0, ROW_PREDICT, '0},
        '{16'sd12345,  1'b0, ROW_PREDICT, '0},
        '{16'sd12344,  1'b0, ROW_PREDICT, '0},
        '{16'sd0,      1'b1, ROW_NO_PEAK, '0}
    };

    spectral_peak_interpolator #(
        .MAX_FRAME(FRAME_BINS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic flag(input string what);
        $display("mismatch @%0t: %s", $time, what);
        mismatches++;
    endtask

    // three-point parabola through the window centered on the previous bin
    function automatic bit fit_parabola(input logic signed [SAMPLE_W-1:0] s, input logic fs,
                                        output peak_t res);
        longint mm, zz, pp, a2, b2, an, bn, num, freq, corr, pw;
        bit hit;
        res = '0;
        fit_parabola = 1'b0;
        if (fs)
        begin
            bin_count = 0;
            peak_count = 0;
            hist_old = '0;
            hist_new = '0;
        end
        if (bin_count >= FRAME_BINS)
            return 1'b0;
        if (bin_count >= 2)
        begin
            mm = hist_old;
            zz = hist_new;
            pp = s;
            if (mode_sh)
                hit = (mm < zz) && (zz > pp);
            else
                hit = (mm > zz) && (zz < pp);
            if (hit && zz > longint'(thr_sh))
            begin
                a2 = pp + mm - 2 * zz;
                b2 = pp - mm;
                if (a2 != 0)
                begin
                    an = (a2 < 0) ? -a2 : a2;
                    bn = (a2 < 0) ? -b2 : b2;
                    num = 2 * an * longint'(bin_count - 1) - bn;
                    freq = 0;
                    if (num > 0)
                        freq = (num * longint'(spacing_sh)) / (2 * an);
                    if (freq > longint'(FREQ_MAX))
                        freq = longint'(FREQ_MAX);
                    corr = (b2 * b2) / (8 * an);
                    pw = (a2 < 0) ? zz + corr : zz - corr;
                    if (pw > 131071)
                        pw = 131071;
                    if (pw < -131072)
                        pw = -131072;
                    res.freq = freq[FREQ_W-1:0];
                    res.power = pw[POWER_W-1:0];
                    res.bin = BIN_W'(bin_count - 1);
                    res.ord = ORD_W'(peak_count);
                    if (peak_count < 127)
                        peak_count++;
                    fit_parabola = 1'b1;
                end
            end
        end
        hist_old = hist_new;
        hist_new = s;
        bin_count++;
    endfunction

    task automatic configure(input logic m, input logic signed [SAMPLE_W-1:0] thr,
                             input logic [SPACING_W-1:0] bs);
        cfg_we <= 1'b1;
        cfg_index <= CFG_PEAK_MODE;
        cfg_data <= {{(SAMPLE_W-1){1'b0}}, m};
        @(posedge clk);
        cfg_index <= CFG_THRESHOLD;
        cfg_data <= thr;
        @(posedge clk);
        cfg_index <= CFG_BIN_SPACING;
        cfg_data <= bs;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_sh = m;
        thr_sh = thr;
        spacing_sh = bs;
    endtask

    task automatic send_bin(input logic signed [SAMPLE_W-1:0] s, input logic fs,
                            input row_kind_t kind, input peak_t want);
        int gap;
        peak_t res;
        bit got;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(0, 3);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= s;
        s_axis_tuser <= fs;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        got = fit_parabola(s, fs, res);
        if (kind == ROW_PEAK)
            expected_peaks.push_back(want);
        else if (kind == ROW_PREDICT && got)
            expected_peaks.push_back(res);
    endtask

    task automatic drain();
        while (expected_peaks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 7))
            0, 1: v = SAMPLE_W'($urandom);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = 16'sh7FFF;
                    1: v = 16'sh8000;
                    2: v = 16'sd0;
                    default: v = -16'sd1;
                endcase
            end
            default: v = SAMPLE_W'($urandom_range(0, 12000)) - 16'sd3000;
        endcase
        return v;
    endfunction

    // receiver stall pattern: always ready, random, or long stalls
    int rx_mode = 0;
    int rx_hold = 0;
    int rx_age = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_age++;
            if (rx_age == 300)
            begin
                rx_age = 0;
                rx_mode = $urandom_range(0, 2);
            end
            if (rx_hold > 0)
                rx_hold--;
            else
            begin
                case (rx_mode)
                    0:
                    begin
                        m_axis_tready <= 1'b1;
                        rx_hold = 0;
                    end
                    1:
                    begin
                        m_axis_tready <= 1'($urandom_range(0, 1));
                        rx_hold = $urandom_range(0, 3);
                    end
                    default:
                    begin
                        m_axis_tready <= ~m_axis_tready;
                        rx_hold = m_axis_tready ? $urandom_range(10, 60) : $urandom_range(1, 5);
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        peak_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.freq = m_axis_tdata[23:0];
            got.power = m_axis_tdata[41:24];
            got.bin = m_axis_tdata[48:42];
            got.ord = m_axis_tdata[55:49];
            if (expected_peaks.size() == 0)
                flag($sformatf("unexpected result bin %0d", got.bin));
            else
            begin
                want = expected_peaks.pop_front();
                if (got.freq !== want.freq)
                    flag($sformatf("bin %0d frequency %0d, want %0d",
                                   want.bin, got.freq, want.freq));
                if (got.power !== want.power)
                    flag($sformatf("bin %0d power %0d, want %0d",
                                   want.bin, got.power, want.power));
                if (got.bin !== want.bin)
                    flag($sformatf("bin_index %0d, want %0d", got.bin, want.bin));
                if (got.ord !== want.ord)
                    flag($sformatf("bin %0d ordinal %0d, want %0d",
                                   want.bin, got.ord, want.ord));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int counted;
        int frame_len;
        int frame_no;
        bit long_frame;
        logic m;
        logic signed [SAMPLE_W-1:0] thr;
        logic [SPACING_W-1:0] bs;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // defaults after reset, no frame mark on the first bins
        foreach (dir_rows[i])
            send_bin(dir_rows[i].smp, dir_rows[i].fs, dir_rows[i].kind, dir_rows[i].want);
        s_axis_tvalid <= 1'b0;
        drain();

        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: configure(1'b0, 16'sh8000, 16'd0);
                1: configure(1'b1, 16'sh7FFF, 16'hFFFF);
                2: configure(1'b1, 16'sh8000, 16'hFFFF);
                3: configure(1'b0, 16'sd0, 16'd1);
                default:
                begin
                    m = 1'($urandom_range(0, 1));
                    thr = SAMPLE_W'($urandom_range(0, 4000)) - 16'sd1000;
                    bs = SPACING_W'($urandom);
                    configure(m, thr, bs);
                end
            endcase
            counted = 0;
            frame_no = 0;
            while (counted < RANDOM_PER_PHASE)
            begin
                // in phase 2, the first frame runs past the last bin
                long_frame = (phase == 2 && frame_no == 0);
                if (long_frame)
                    frame_len = $urandom_range(130, 134);
                else if ($urandom_range(0, 19) == 0)
                    frame_len = $urandom_range(126, 134);
                else if ($urandom_range(0, 9) == 0)
                    frame_len = $urandom_range(25, 80);
                else
                    frame_len = $urandom_range(1, 24);
                for (int k = 0; k < frame_len && (counted < RANDOM_PER_PHASE || long_frame);
                     k++)
                begin
                    if (k == 0 || bin_count < FRAME_BINS)
                        counted++;
                    send_bin(pick_sample(), k == 0, ROW_PREDICT, '0);
                end
                frame_no++;
            end
            s_axis_tvalid <= 1'b0;
            drain();
        end

        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// File: sim.f
hdl/spi_pkg.sv
hdl/spi_div.sv
hdl/spectral_peak_interpolator.sv
test/tb.sv
